>>> src/tpem_pkg.sv
package tpem_pkg;

	localparam int MaxEntries = 64;
	localparam int IdxW       = $clog2(MaxEntries);
	localparam int WordW      = 32;
	localparam int LgW        = 3;

	localparam logic [LgW-1:0] LgMin   = LgW'(2);
	localparam logic [LgW-1:0] LgMax   = LgW'(IdxW);
	localparam logic [LgW-1:0] LgReset = LgW'(6);

	localparam logic CmdKeyWrite = 1'b0;
	localparam logic CmdRun      = 1'b1;

	typedef struct packed {
		logic             command;
		logic [IdxW-1:0]  key_index;
		logic [WordW-1:0] key_word;
		logic [IdxW-1:0]  chosen_path;
		logic [WordW-1:0] random_mask;
		logic [WordW-1:0] value_zero;
		logic [WordW-1:0] value_one;
		logic [WordW-1:0] value_two;
		logic [WordW-1:0] value_three;
		logic [IdxW-1:0]  rotation;
	} in_beat_t;

	typedef struct packed {
		logic [IdxW-1:0]  position;
		logic [WordW-1:0] masked_word;
		logic             last;
	} out_beat_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

endpackage

>>> src/transfer_path_encode_mask_core.sv
// channel | handshake            | payload
// cfg     | cfg_we               | cfg_wdata (path_size_log2)
// in      | in_valid / in_ready  | in_data  (in_beat_t)
// out     | out_valid / out_ready| out_data (out_beat_t)
//
// A key write beat is accepted while idle and writes one key memory word. A run
// beat issues size = 2^path_size_log2 (4..64) key memory reads, one per cycle
// while the output does not stall, as the key memory has a single read port;
// each word passes the s1 register and the output register. in_ready is high
// again once the last read of a run is issued. Output stalls hold the sequencer.
// Reset clears control only; key memory contents stay undefined until written.
module transfer_path_encode_mask_core
	import tpem_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [LgW-1:0]  cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_beat_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_beat_t       out_data
);

	logic [WordW-1:0] key_mem [MaxEntries];
	logic [WordW-1:0] rd_q;

	logic [LgW-1:0]   lg_q;
	logic [LgW-1:0]   lg_eff;
	logic [IdxW-1:0]  size_mask;
	logic [IdxW:0]    mask_lim;

	seq_state_t       state_q, state_d;
	logic [IdxW-1:0]  idx_q;
	in_beat_t         run_q;

	logic             in_fire;
	logic             issue;
	logic             issue_ok;
	logic             adv1;

	logic [IdxW-1:0]  kidx;
	logic [IdxW-1:0]  tsel;
	logic [WordW-1:0] vsel;
	logic [WordW-1:0] entry;

	logic             s1_valid;
	logic [WordW-1:0] entry_s1;
	logic [IdxW-1:0]  pos_s1;
	logic             last_s1;

	logic             out_valid_q;
	out_beat_t        out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= LgReset;
		end else if (cfg_we) begin
			lg_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (lg_q < LgMin) begin
			lg_eff = LgMin;
		end else if (lg_q > LgMax) begin
			lg_eff = LgMax;
		end else begin
			lg_eff = lg_q;
		end
		size_mask = IdxW'(((IdxW+1)'(1) << lg_eff) - (IdxW+1)'(1));
		mask_lim  = {1'b0, size_mask} - (IdxW+1)'(3);
	end

	assign in_fire  = in_valid && in_ready;
	assign adv1     = s1_valid && (!out_valid_q || out_ready);
	assign issue_ok = !s1_valid || adv1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_data.command == CmdRun) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue && idx_q == size_mask) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_RUN:  issue    = issue_ok;
			default: begin
				in_ready = 1'b0;
				issue    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_data.command == CmdRun) begin
			run_q <= in_data;
		end
	end

	assign kidx = (idx_q - run_q.rotation) & size_mask;
	assign tsel = run_q.chosen_path ^ idx_q;

	always_comb begin
		case (tsel[1:0])
			2'd0:    vsel = run_q.value_zero;
			2'd1:    vsel = run_q.value_one;
			2'd2:    vsel = run_q.value_two;
			default: vsel = run_q.value_three;
		endcase
		if ({1'b0, tsel} < mask_lim) begin
			entry = run_q.random_mask;
		end else begin
			entry = vsel + run_q.random_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_data.command == CmdKeyWrite) begin
			key_mem[in_data.key_index] <= in_data.key_word;
		end
		if (issue) begin
			rd_q <= key_mem[kidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (issue_ok) begin
			s1_valid <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			entry_s1 <= entry;
			pos_s1   <= idx_q;
			last_s1  <= (idx_q == size_mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			out_q.position    <= pos_s1;
			out_q.masked_word <= entry_s1 ^ rd_q;
			out_q.last        <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> src/tpem_checker.sv
module tpem_checker
	import tpem_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            cfg_we,
	input logic [LgW-1:0]  cfg_wdata,
	input logic            in_valid,
	input logic            in_ready,
	input in_beat_t        in_data,
	input logic            out_valid,
	input logic            out_ready,
	input out_beat_t       out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("out beat dropped or changed while stalled");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.command == CmdRun |=> !in_ready)
		else $error("in_ready high right after a run beat");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.position[1:0] == 2'd3)
		else $error("last beat at a position that cannot end a table");

	a_pos_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last && out_data.position[1:0] != 2'd3
		|=> out_valid && out_data.position == $past(out_data.position) + IdxW'(1))
		else $error("entries within a run not back to back");

endmodule

bind transfer_path_encode_mask_core tpem_checker u_tpem_checker (.*);
